// ===== sv/s3f_pkg.sv =====
// ----------------------------------------------------------------------------
// S3-FIFO policy package
// Shared widths, ring entry type, outcome and register codes, limit clamp.
// ----------------------------------------------------------------------------
`default_nettype none
package s3f_pkg;
  localparam int CAP_BITS = 8;
  localparam int CNT_BITS = 9;
  localparam int ID_BITS  = 16;
  localparam int HOT_BITS = 8;
  localparam int ADDR_BITS = 4;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_GHOST = 2'd1;
  localparam logic [1:0] OUT_NEW   = 2'd2;

  localparam logic [1:0] REG_SMALL = 2'd0;
  localparam logic [1:0] REG_MAIN  = 2'd1;
  localparam logic [1:0] REG_HOT   = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [HOT_BITS-1:0] hot;
  } slot_t;

  // Limits are saturated into 1..256.
  function automatic logic [CNT_BITS-1:0] clamp_limit(input logic [CNT_BITS-1:0] v);
    logic [CNT_BITS-1:0] r;
    begin
      r = v;
      if (v == '0) r = CNT_BITS'(1);
      else if (v > CNT_BITS'(256)) r = CNT_BITS'(256);
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== sv/s3f_ram.sv =====
// ----------------------------------------------------------------------------
// S3-FIFO ring memory
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module s3f_ram #(
  parameter int W = 24
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [s3f_pkg::CAP_BITS-1:0] waddr,
  input  wire logic [W-1:0]              wdata,
  input  wire logic [s3f_pkg::CAP_BITS-1:0] raddr,
  output logic      [W-1:0]              rdata
);
  logic [W-1:0] mem [0:(1<<s3f_pkg::CAP_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/s3_fifo_replacement_policy_unit.sv =====
// ----------------------------------------------------------------------------
// S3-FIFO replacement policy unit
// Small, main and ghost FIFOs of ids in ring memories, run by one sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                          | role
//  in      | in_valid/ready, in_access_id   | one access id per word
//  out     | out_valid/ready, out_outcome,  | one result word per access
//          | out_left_valid, out_left_id    |
//  cfg     | cfg_psel ... cfg_pready        | limits and hotness cap
// An access walks main, then small, then ghost, reading and then comparing
// each entry, and on a ghost hit shifts the later ghost entries down to close
// the gap. Main eviction reads and checks every head it looks at, putting hot
// heads back at the tail with one less hotness. Each ring has a single read
// port, so entries are visited one at a time. Reset is synchronous; ring
// contents need none.
// in_ready is low from acceptance until the result word is taken.
`default_nettype none
module s3_fifo_replacement_policy_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_access_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_outcome,
  output logic             out_left_valid,
  output logic [15:0]      out_left_id,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int CB = s3f_pkg::CAP_BITS;
  localparam int NB = s3f_pkg::CNT_BITS;
  localparam int IB = s3f_pkg::ID_BITS;
  localparam int HB = s3f_pkg::HOT_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_MREAD, S_MCMP, S_SREAD, S_SCMP, S_GREAD, S_GCMP,
    S_GSHREAD, S_GSHWR, S_DECIDE, S_SPOP, S_SPOPCHK, S_EVREAD, S_EVCHK,
    S_MAPPEND, S_SAPPEND, S_DONE
  } state_t;

  state_t state_r;
  logic [NB-1:0] small_limit_r, main_limit_r;
  logic [HB-1:0] max_hot_r;
  logic [CB-1:0] s_head_r, m_head_r, g_head_r;
  logic [NB-1:0] s_cnt_r, m_cnt_r, g_cnt_r;
  logic [NB-1:0] idx_r;
  logic [IB-1:0] id_r, left_id_r, mov_id_r;
  logic [1:0]    outcome_r;
  logic          gone_r, promote_r;

  // memories
  logic          s_we, m_we, g_we;
  logic [CB-1:0] s_wa, m_wa, g_wa, s_ra, m_ra, g_ra;
  s3f_pkg::slot_t s_wd, m_wd, s_rd, m_rd;
  logic [IB-1:0] g_wd, g_rd;

  s3f_ram #(.W(IB+HB)) u_small (.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
                                .raddr(s_ra), .rdata(s_rd));
  s3f_ram #(.W(IB+HB)) u_main  (.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd),
                                .raddr(m_ra), .rdata(m_rd));
  s3f_ram #(.W(IB))    u_ghost (.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd),
                                .raddr(g_ra), .rdata(g_rd));

  logic [NB-1:0] s_lim, m_lim;
  assign s_lim = s3f_pkg::clamp_limit(small_limit_r);
  assign m_lim = s3f_pkg::clamp_limit(main_limit_r);

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[3:2])
      s3f_pkg::REG_SMALL: cfg_prdata = {23'd0, small_limit_r};
      s3f_pkg::REG_MAIN:  cfg_prdata = {23'd0, main_limit_r};
      s3f_pkg::REG_HOT:   cfg_prdata = {24'd0, max_hot_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_DONE);
  assign out_outcome    = outcome_r;
  assign out_left_valid = gone_r;
  assign out_left_id    = gone_r ? left_id_r : '0;

  // Read addresses follow the index register; eviction and small-pop reads use the head.
  assign m_ra = (state_r == S_EVREAD) ? m_head_r : m_head_r + idx_r[CB-1:0];
  assign s_ra = (state_r == S_SPOP) ? s_head_r : s_head_r + idx_r[CB-1:0];
  assign g_ra = g_head_r + idx_r[CB-1:0];

  always_comb begin
    s_we = 1'b0; s_wa = s_ra; s_wd = s_rd;
    m_we = 1'b0; m_wa = m_ra; m_wd = m_rd;
    g_we = 1'b0; g_wa = g_ra; g_wd = g_rd;
    case (state_r)
      S_MCMP: begin
        m_we = (m_rd.id == id_r) && (m_rd.hot < max_hot_r);
        m_wd.hot = m_rd.hot + HB'(1);
      end
      S_SCMP: begin
        s_we = (s_rd.id == id_r) && (s_rd.hot < max_hot_r);
        s_wd.hot = s_rd.hot + HB'(1);
      end
      S_GSHWR: begin
        g_we = 1'b1;
        g_wa = g_head_r + CB'(idx_r - NB'(1));
      end
      S_SPOPCHK: begin
        // Cold head goes to ghost. On overflow the head moves up by one, so
        // the new tail slot lands on head plus count either way.
        g_we = (s_rd.hot == '0);
        g_wa = g_head_r + g_cnt_r[CB-1:0];
        g_wd = s_rd.id;
      end
      S_EVCHK: begin
        m_we = (m_rd.hot != '0);
        m_wa = m_head_r + m_cnt_r[CB-1:0];
        m_wd.hot = m_rd.hot - HB'(1);
      end
      S_MAPPEND: begin
        m_we = 1'b1;
        m_wa = m_head_r + m_cnt_r[CB-1:0];
        m_wd.id = promote_r ? mov_id_r : id_r;
        m_wd.hot = '0;
      end
      S_SAPPEND: begin
        s_we = 1'b1;
        s_wa = s_head_r + s_cnt_r[CB-1:0];
        s_wd.id = id_r;
        s_wd.hot = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      small_limit_r <= NB'(32); main_limit_r <= NB'(224); max_hot_r <= 8'd255;
      s_head_r <= '0; m_head_r <= '0; g_head_r <= '0;
      s_cnt_r <= '0; m_cnt_r <= '0; g_cnt_r <= '0;
      gone_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          s3f_pkg::REG_SMALL: small_limit_r <= cfg_pwdata[NB-1:0];
          s3f_pkg::REG_MAIN:  main_limit_r  <= cfg_pwdata[NB-1:0];
          s3f_pkg::REG_HOT:   max_hot_r     <= cfg_pwdata[HB-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          id_r <= in_access_id; idx_r <= '0; gone_r <= 1'b0; left_id_r <= '0;
          promote_r <= 1'b0; outcome_r <= s3f_pkg::OUT_HIT;
          state_r <= S_MREAD;
        end
        S_MREAD: state_r <= (idx_r < m_cnt_r) ? S_MCMP : S_SREAD;
        S_MCMP: begin
          if (m_rd.id == id_r) state_r <= S_DONE;
          else if (idx_r + NB'(1) >= m_cnt_r) begin
            idx_r <= '0;
            state_r <= S_SREAD;
          end else begin
            idx_r <= idx_r + NB'(1);
            state_r <= S_MREAD;
          end
        end
        S_SREAD: state_r <= (idx_r < s_cnt_r) ? S_SCMP : S_GREAD;
        S_SCMP: begin
          if (s_rd.id == id_r) state_r <= S_DONE;
          else if (idx_r + NB'(1) >= s_cnt_r) begin
            idx_r <= '0;
            state_r <= S_GREAD;
          end else begin
            idx_r <= idx_r + NB'(1);
            state_r <= S_SREAD;
          end
        end
        S_GREAD: state_r <= (idx_r < g_cnt_r) ? S_GCMP : S_DECIDE;
        S_GCMP: begin
          if (g_rd == id_r) begin
            outcome_r <= s3f_pkg::OUT_GHOST;
            idx_r <= idx_r + NB'(1);
            state_r <= S_GSHREAD;
          end else begin
            idx_r <= idx_r + NB'(1);
            state_r <= S_GREAD;
          end
        end
        // Close the gap: move entry idx down to idx-1.
        S_GSHREAD: begin
          if (idx_r < g_cnt_r) state_r <= S_GSHWR;
          else begin
            g_cnt_r <= g_cnt_r - NB'(1);
            state_r <= (m_cnt_r >= m_lim && m_cnt_r != '0) ? S_EVREAD : S_MAPPEND;
          end
        end
        S_GSHWR: begin
          idx_r <= idx_r + NB'(1);
          state_r <= S_GSHREAD;
        end
        S_DECIDE: begin
          outcome_r <= s3f_pkg::OUT_NEW;
          state_r <= (s_cnt_r >= s_lim && s_cnt_r != '0) ? S_SPOP : S_SAPPEND;
        end
        S_SPOP: state_r <= S_SPOPCHK;
        S_SPOPCHK: begin
          s_head_r <= s_head_r + CB'(1);
          s_cnt_r  <= s_cnt_r - NB'(1);
          if (s_rd.hot == '0) begin
            gone_r <= 1'b1; left_id_r <= s_rd.id;
            if (g_cnt_r >= m_lim && g_cnt_r != '0) g_head_r <= g_head_r + CB'(1);
            else g_cnt_r <= g_cnt_r + NB'(1);
            state_r <= S_SAPPEND;
          end else begin
            promote_r <= 1'b1; mov_id_r <= s_rd.id;
            state_r <= (m_cnt_r >= m_lim && m_cnt_r != '0) ? S_EVREAD : S_MAPPEND;
          end
        end
        S_EVREAD: state_r <= S_EVCHK;
        S_EVCHK: begin
          m_head_r <= m_head_r + CB'(1);
          if (m_rd.hot == '0) begin
            m_cnt_r <= m_cnt_r - NB'(1);
            gone_r <= 1'b1; left_id_r <= m_rd.id;
            state_r <= S_MAPPEND;
          end else state_r <= S_EVREAD;
        end
        S_MAPPEND: begin
          m_cnt_r <= m_cnt_r + NB'(1);
          state_r <= promote_r ? S_SAPPEND : S_DONE;
        end
        S_SAPPEND: begin
          s_cnt_r <= s_cnt_r + NB'(1);
          state_r <= S_DONE;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s_cnt_r <= NB'(256)) && (m_cnt_r <= NB'(256)) && (g_cnt_r <= NB'(256)))
    else $error("ring count above capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_id))
    else $error("result word changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");
`endif
endmodule
`default_nettype wire

// ===== tb/s3f_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3-FIFO policy checker
// Watches the access, result and register ports, keeps its own copy of the
// three FIFOs and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module s3f_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_access_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_outcome,
  input  logic        out_left_valid,
  input  logic [15:0] out_left_id,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          outstanding
);
  typedef struct packed {
    logic [1:0]  outcome;
    logic        left_valid;
    logic [15:0] left_id;
  } verdict_t;

  verdict_t pending_q[$];

  logic [8:0] small_lim, main_lim;
  logic [7:0] hot_cap;

  logic [15:0] sm_id [256];
  logic [7:0]  sm_hot[256];
  logic [15:0] mn_id [256];
  logic [7:0]  mn_hot[256];
  logic [15:0] gh_id [256];
  logic [7:0]  sm_head, mn_head, gh_head;
  int          sm_cnt, mn_cnt, gh_cnt;

  assign outstanding = pending_q.size();

  function automatic int sat_limit(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // Pops main until a cold head is found; hot heads lose one and go back.
  function automatic logic [15:0] main_evict();
    logic [15:0] eid;
    logic [7:0]  ehot;
    forever begin
      eid = mn_id[mn_head];
      ehot = mn_hot[mn_head];
      mn_head = mn_head + 8'd1;
      if (ehot == 0) begin
        mn_cnt--;
        return eid;
      end
      mn_id[8'(mn_head + mn_cnt - 1)] = eid;
      mn_hot[8'(mn_head + mn_cnt - 1)] = ehot - 8'd1;
    end
  endfunction

  function automatic logic main_append(input logic [15:0] id, output logic [15:0] gone_id);
    logic gone;
    gone = 1'b0;
    gone_id = '0;
    if (mn_cnt >= sat_limit(main_lim) && mn_cnt > 0) begin
      gone_id = main_evict();
      gone = 1'b1;
    end
    if (mn_cnt < 256) begin
      mn_id[8'(mn_head + mn_cnt)] = id;
      mn_hot[8'(mn_head + mn_cnt)] = '0;
      mn_cnt++;
    end
    return gone;
  endfunction

  function automatic void ghost_append(input logic [15:0] id);
    if (gh_cnt >= sat_limit(main_lim) && gh_cnt > 0) begin
      gh_head = gh_head + 8'd1;
      gh_cnt--;
    end
    if (gh_cnt < 256) begin
      gh_id[8'(gh_head + gh_cnt)] = id;
      gh_cnt++;
    end
  endfunction

  function automatic verdict_t serve_access(input logic [15:0] id);
    verdict_t r;
    logic     hit, found;
    logic [15:0] hid;
    logic [7:0]  hhot;
    r = '0;
    hit = 1'b0;
    found = 1'b0;
    for (int i = 0; i < mn_cnt && !hit; i++)
      if (mn_id[8'(mn_head + i)] == id) begin
        hit = 1'b1;
        if (mn_hot[8'(mn_head + i)] < hot_cap) mn_hot[8'(mn_head + i)]++;
      end
    for (int i = 0; i < sm_cnt && !hit; i++)
      if (sm_id[8'(sm_head + i)] == id) begin
        hit = 1'b1;
        if (sm_hot[8'(sm_head + i)] < hot_cap) sm_hot[8'(sm_head + i)]++;
      end
    if (hit) begin
      r.outcome = s3f_pkg::OUT_HIT;
      return r;
    end
    for (int i = 0; i < gh_cnt && !found; i++)
      if (gh_id[8'(gh_head + i)] == id) begin
        for (int k = i; k + 1 < gh_cnt; k++)
          gh_id[8'(gh_head + k)] = gh_id[8'(gh_head + k + 1)];
        gh_cnt--;
        found = 1'b1;
      end
    if (found) begin
      r.outcome = s3f_pkg::OUT_GHOST;
      r.left_valid = main_append(id, r.left_id);
      return r;
    end
    r.outcome = s3f_pkg::OUT_NEW;
    if (sm_cnt >= sat_limit(small_lim) && sm_cnt > 0) begin
      hid = sm_id[sm_head];
      hhot = sm_hot[sm_head];
      sm_head = sm_head + 8'd1;
      sm_cnt--;
      if (hhot == 0) begin
        ghost_append(hid);
        r.left_valid = 1'b1;
        r.left_id = hid;
      end else begin
        r.left_valid = main_append(hid, r.left_id);
      end
    end
    if (sm_cnt < 256) begin
      sm_id[8'(sm_head + sm_cnt)] = id;
      sm_hot[8'(sm_head + sm_cnt)] = '0;
      sm_cnt++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      small_lim <= 9'd32;
      main_lim <= 9'd224;
      hot_cap <= 8'd255;
      sm_head = '0; mn_head = '0; gh_head = '0;
      sm_cnt = 0; mn_cnt = 0; gh_cnt = 0;
      pending_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          s3f_pkg::REG_SMALL: small_lim <= cfg_pwdata[8:0];
          s3f_pkg::REG_MAIN:  main_lim <= cfg_pwdata[8:0];
          s3f_pkg::REG_HOT:   hot_cap <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("ERROR %0t: result word with nothing expected", $realtime);
        end else begin
          want = pending_q.pop_front();
          if (want.outcome !== out_outcome || want.left_valid !== out_left_valid ||
              want.left_id !== out_left_id) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR %0t: expected outcome %0d left %0d id %h, got %0d %0d %h",
                       $realtime, want.outcome, want.left_valid, want.left_id,
                       out_outcome, out_left_valid, out_left_id);
          end
        end
      end
      if (in_valid && in_ready)
        pending_q.push_back(serve_access(in_access_id));
    end
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3-FIFO policy unit testbench
// Directed and random access streams under several limit settings, with
// random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  localparam longint CYCLE_LIMIT = 1_000_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [15:0] in_access_id;
  logic        out_valid, out_ready;
  logic [1:0]  out_outcome;
  logic        out_left_valid;
  logic [15:0] out_left_id;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  int     fail_count, outstanding;
  int     words_sent;
  int     tx_idle_pct, rx_idle_pct;
  logic   rx_hold;
  longint cycle_count;

  s3_fifo_replacement_policy_unit u_top (.*);

  s3f_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_access_id,
    .out_valid, .out_ready, .out_outcome, .out_left_valid, .out_left_id,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .outstanding
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);

  // Long result stall so the unit backs up and holds off new words.
  initial begin
    rx_hold = 1'b0;
    wait (words_sent >= 600);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // in_valid stays high after an accepted word until the next idle cycle or
  // pause drops it, so it is never written twice at one edge.
  task automatic send_access(input logic [15:0] id);
    if (words_sent == 390) begin
      tx_idle_pct = 80; rx_idle_pct = 34;
    end else if (words_sent == 780) begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
    if (words_sent == 900) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_access_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Most ids come from a small pool so hits and ghost returns are common.
  task automatic run_phase(input logic [31:0] s_lim, input logic [31:0] m_lim,
                           input logic [31:0] h_cap, input int n, input int pool);
    logic [15:0] base;
    settle();
    cfg_write(s3f_pkg::REG_SMALL, s_lim);
    cfg_write(s3f_pkg::REG_MAIN, m_lim);
    cfg_write(s3f_pkg::REG_HOT, h_cap);
    base = 16'($urandom);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 99) < 80) send_access(base + 16'($urandom_range(0, pool - 1)));
      else send_access(16'($urandom));
  endtask

  initial begin
    logic [15:0] directed[$];
    rst_n = 1'b0;
    in_valid = 1'b0; in_access_id = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    cycle_count = 0; words_sent = 0;
    tx_idle_pct = 34; rx_idle_pct = 80;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Tiny FIFOs: hot promotion, cold drop to ghost, ghost return, main full.
    cfg_write(s3f_pkg::REG_SMALL, 1);
    cfg_write(s3f_pkg::REG_MAIN, 2);
    cfg_write(s3f_pkg::REG_HOT, 1);
    directed = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0002,
                 16'h0002, 16'h0003, 16'h0001, 16'hFFFF, 16'h0000, 16'h0004,
                 16'h0002, 16'h0005, 16'h0003, 16'hAAAA, 16'h5555, 16'hAAAA,
                 16'h0005, 16'h8000};
    foreach (directed[i]) send_access(directed[i]);

    run_phase(0, 0, 0, 150, 8);
    run_phase(4, 8, 3, 250, 24);
    run_phase(16, 32, 255, 250, 80);
    run_phase(511, 300, 7, 120, 600);
    run_phase(2, 16, 2, 200, 20);
    run_phase(256, 1, 255, 100, 300);
    run_phase(8, 12, 1, 80, 30);

    settle();
    repeat (50) @(posedge clk);
    $display("Ran %0d accesses over eight limit settings, including saturated limits,", words_sent);
    $display("zero and maximum hotness caps, a long result stall and idle-free stretches.");
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== files.f =====
sv/s3f_pkg.sv
sv/s3f_ram.sv
sv/s3_fifo_replacement_policy_unit.sv
tb/s3f_checker.sv
tb/tb_top.sv
